// ===== rtl/tspe_pkg.sv =====
// Shared types and constants for the touch sample to pointer event block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tspe_pkg;

    // Fixed widths of the raw sample fields and of the configuration registers
    localparam int RAW_BITS = 16;
    localparam int CFG_BITS = 16;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_CAL_ENABLE   = 3'd0,
        REG_X_SCALE      = 3'd1,
        REG_X_OFFSET     = 3'd2,
        REG_Y_SCALE      = 3'd3,
        REG_Y_OFFSET     = 3'd4,
        REG_CLICK_WINDOW = 3'd5
    } cfg_reg_t;

    // Event kinds on the output stream
    typedef enum logic [1:0] {
        EV_MOVE = 2'd0,
        EV_DOWN = 2'd1,
        EV_UP   = 2'd2
    } event_kind_t;

    // Reset values of the configuration registers
    localparam logic signed [CFG_BITS-1:0] SCALE_RESET        = 16'sd256;
    localparam logic signed [CFG_BITS-1:0] OFFSET_RESET       = 16'sd0;
    localparam logic [CFG_BITS-1:0]        CLICK_WINDOW_RESET = 16'd250;

    // Calibration of one axis
    typedef struct packed {
        logic signed [CFG_BITS-1:0] scale;
        logic signed [CFG_BITS-1:0] offset;
    } axis_cal_t;

endpackage

`default_nettype wire

// ===== rtl/touch_sample_to_pointer_events.sv =====
// Top level of the touch sample to pointer event converter.
// Depends on tspe_pkg and tspe_axis_map.
`timescale 1ns / 1ps
`default_nettype none

// Turns a stream of raw touch samples into pointer events. Each sample is
// mapped to a position (optional per-axis gain/offset, saturated to a signed
// COORD_BITS coordinate) and compared with the previous sample: a sample that
// is pressed, or follows a pressed one, gives a move event; a press edge adds
// a down event tagged double/triple click against the two most recent press
// times; a release edge adds an up event at the previous position repeating
// those flags. tlast marks the final event of a sample; a sample with no
// contact after one with no contact gives no event. A sample passes the
// input register, the mapping register and the event queue, in that order,
// and stalls in either register while the stage after it is full. A new
// sample is taken every cycle while nothing stalls; the output gives one
// transfer per cycle, so runs of samples giving two events (press or release
// edges) fill the four-entry event queue and then hold the input back.
// Configuration must only be written while no sample is in flight.
module touch_sample_to_pointer_events
    import tspe_pkg::*;
#(
    parameter int COORD_BITS      = 16,
    parameter int SCALE_FRAC_BITS = 8,
    parameter int TIME_BITS       = 32,
    localparam int IN_FIELD_BITS  = 3 * RAW_BITS + TIME_BITS,
    localparam int IN_BITS        = ((IN_FIELD_BITS + 7) / 8) * 8,
    localparam int OUT_FIELD_BITS = 2 * COORD_BITS + 2,
    localparam int OUT_BITS       = ((OUT_FIELD_BITS + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,

    // configuration write port
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,

    // sample input
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_BITS-1:0]  s_tdata,   // raw_x, raw_y, pressure, sample_time

    // event output
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_BITS-1:0] m_tdata,   // pos_x, pos_y, dbl_click, trp_click
    output logic [1:0]          m_tuser,   // event_kind
    output logic                m_tlast    // last_of_run
);

    localparam int QDEPTH   = 4;
    localparam int CMP_BITS = (TIME_BITS > CFG_BITS + 1) ? TIME_BITS : CFG_BITS + 1;

    typedef struct packed {
        event_kind_t                  kind;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic                         dbl_click;
        logic                         trp_click;
        logic                         last;
    } evt_t;

    // ---------------- configuration registers ----------------
    logic                cal_enable_reg;
    axis_cal_t           x_cal_reg;
    axis_cal_t           y_cal_reg;
    logic [CFG_BITS-1:0] click_window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_enable_reg   <= 1'b0;
            x_cal_reg        <= '{scale: SCALE_RESET, offset: OFFSET_RESET};
            y_cal_reg        <= '{scale: SCALE_RESET, offset: OFFSET_RESET};
            click_window_reg <= CLICK_WINDOW_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CAL_ENABLE:   cal_enable_reg   <= cfg_data[0];
                REG_X_SCALE:      x_cal_reg.scale  <= $signed(cfg_data);
                REG_X_OFFSET:     x_cal_reg.offset <= $signed(cfg_data);
                REG_Y_SCALE:      y_cal_reg.scale  <= $signed(cfg_data);
                REG_Y_OFFSET:     y_cal_reg.offset <= $signed(cfg_data);
                REG_CLICK_WINDOW: click_window_reg <= cfg_data;
                default:          ; // unknown index: ignored
            endcase
        end
    end

    // ---------------- stage A: input register ----------------
    logic                 a_valid_reg;
    logic [RAW_BITS-1:0]  a_raw_x_reg;
    logic [RAW_BITS-1:0]  a_raw_y_reg;
    logic                 a_pressed_reg;
    logic [TIME_BITS-1:0] a_time_reg;
    logic                 a_adv;
    logic                 s_accept;

    // ---------------- stage B: mapped sample ----------------
    logic                         b_valid_reg;
    logic signed [COORD_BITS-1:0] b_x_reg;
    logic signed [COORD_BITS-1:0] b_y_reg;
    logic                         b_pressed_reg;
    logic [TIME_BITS-1:0]         b_time_reg;
    logic                         b_adv;

    logic signed [COORD_BITS-1:0] map_x;
    logic signed [COORD_BITS-1:0] map_y;

    // ---------------- tracking state ----------------
    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;
    logic                         prev_pressed_reg;
    logic [TIME_BITS-1:0]         last_time_reg;
    logic                         last_valid_reg;
    logic [TIME_BITS-1:0]         earlier_time_reg;
    logic                         earlier_valid_reg;
    logic                         double_flag_reg;
    logic                         triple_flag_reg;

    // ---------------- event queue ----------------
    evt_t       q_reg [QDEPTH];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       pop;

    // ---------------- input handshake ----------------
    assign s_accept = s_tvalid && s_tready;
    assign a_adv    = a_valid_reg && (!b_valid_reg || b_adv);
    assign s_tready = !a_valid_reg || a_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= s_accept || (a_valid_reg && !a_adv);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            a_raw_x_reg   <= s_tdata[RAW_BITS-1:0];
            a_raw_y_reg   <= s_tdata[2*RAW_BITS-1:RAW_BITS];
            a_pressed_reg <= (s_tdata[3*RAW_BITS-1:2*RAW_BITS] != '0);
            a_time_reg    <= s_tdata[IN_FIELD_BITS-1:3*RAW_BITS];
        end
    end

    // ---------------- coordinate mapping ----------------
    tspe_axis_map #(
        .COORD_BITS      (COORD_BITS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_map_x (
        .cal_enable (cal_enable_reg),
        .cal        (x_cal_reg),
        .raw        (a_raw_x_reg),
        .pos        (map_x)
    );

    tspe_axis_map #(
        .COORD_BITS      (COORD_BITS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_map_y (
        .cal_enable (cal_enable_reg),
        .cal        (y_cal_reg),
        .raw        (a_raw_y_reg),
        .pos        (map_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_adv || (b_valid_reg && !b_adv);
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            b_x_reg       <= map_x;
            b_y_reg       <= map_y;
            b_pressed_reg <= a_pressed_reg;
            b_time_reg    <= a_time_reg;
        end
    end

    // ---------------- event decision ----------------
    logic                 is_move;
    logic                 is_down;
    logic                 is_edge;
    logic [1:0]           n_res;
    logic [TIME_BITS-1:0] d_last;
    logic [TIME_BITS-1:0] d_earlier;
    logic                 dbl_hit;
    logic                 trp_hit;
    evt_t                 res0;
    evt_t                 res1;

    always_comb
    begin
        is_move = b_pressed_reg || prev_pressed_reg;
        is_edge = b_pressed_reg != prev_pressed_reg;
        is_down = b_pressed_reg && !prev_pressed_reg;

        if (is_edge)
        begin
            n_res = 2'd2;
        end
        else if (is_move)
        begin
            n_res = 2'd1;
        end
        else
        begin
            n_res = 2'd0;
        end

        // gaps are modulo 2^TIME_BITS
        d_last    = b_time_reg - last_time_reg;
        d_earlier = b_time_reg - earlier_time_reg;
        dbl_hit   = last_valid_reg
                 && (CMP_BITS'(d_last) <= CMP_BITS'(click_window_reg));
        trp_hit   = earlier_valid_reg
                 && (CMP_BITS'(d_earlier) <= (CMP_BITS'(click_window_reg) << 1));

        res0.kind      = EV_MOVE;
        res0.pos_x     = b_x_reg;
        res0.pos_y     = b_y_reg;
        res0.dbl_click = 1'b0;
        res0.trp_click = 1'b0;
        res0.last      = !is_edge;

        // second event: down at the new position or up at the old one
        res1.kind      = is_down ? EV_DOWN : EV_UP;
        res1.pos_x     = is_down ? b_x_reg : prev_x_reg;
        res1.pos_y     = is_down ? b_y_reg : prev_y_reg;
        res1.dbl_click = is_down ? dbl_hit : double_flag_reg;
        res1.trp_click = is_down ? trp_hit : triple_flag_reg;
        res1.last      = 1'b1;
    end

    // stage B retires only when the queue has room for all its events
    assign b_adv = b_valid_reg && ((count_reg + 3'(n_res)) <= 3'(QDEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg        <= '0;
            prev_y_reg        <= '0;
            prev_pressed_reg  <= 1'b0;
            last_time_reg     <= '0;
            last_valid_reg    <= 1'b0;
            earlier_time_reg  <= '0;
            earlier_valid_reg <= 1'b0;
            double_flag_reg   <= 1'b0;
            triple_flag_reg   <= 1'b0;
        end
        else if (b_adv)
        begin
            prev_x_reg       <= b_x_reg;
            prev_y_reg       <= b_y_reg;
            prev_pressed_reg <= b_pressed_reg;
            if (is_down)
            begin
                double_flag_reg <= dbl_hit;
                triple_flag_reg <= trp_hit;
                if (trp_hit)
                begin
                    // triple click restarts the press history
                    last_time_reg     <= '0;
                    last_valid_reg    <= 1'b0;
                    earlier_time_reg  <= '0;
                    earlier_valid_reg <= 1'b0;
                end
                else
                begin
                    earlier_time_reg  <= last_time_reg;
                    earlier_valid_reg <= last_valid_reg;
                    last_time_reg     <= b_time_reg;
                    last_valid_reg    <= 1'b1;
                end
            end
        end
    end

    // ---------------- event queue ----------------
    assign pop        = m_tvalid && m_tready;
    assign count_next = count_reg + (b_adv ? 3'(n_res) : 3'd0) - (pop ? 3'd1 : 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (b_adv)
            begin
                wr_ptr_reg <= wr_ptr_reg + n_res;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv && (n_res != 2'd0))
        begin
            q_reg[wr_ptr_reg] <= res0;
        end
        if (b_adv && is_edge)
        begin
            q_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

    // ---------------- output ----------------
    evt_t head;

    assign head     = q_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != 3'd0);
    assign m_tdata  = OUT_BITS'({head.trp_click, head.dbl_click, head.pos_y, head.pos_x});
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

    // ---------------- assertions ----------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(QDEPTH))
        else $error("event queue over-filled");

    a_triple_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (b_adv && is_down && trp_hit) |=> (!last_valid_reg && !earlier_valid_reg))
        else $error("press history not cleared after triple click");

    a_press_recorded: assert property (@(posedge clk) disable iff (!rst_n)
        (b_adv && is_down && !trp_hit)
        |=> (last_valid_reg && (last_time_reg == $past(b_time_reg))))
        else $error("press time not recorded on down event");

endmodule

`default_nettype wire

// ===== rtl/tspe_axis_map.sv =====
// One axis of the coordinate mapper: optional gain/offset calibration, then
// saturation to a signed coordinate. Depends on tspe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tspe_axis_map
    import tspe_pkg::*;
#(
    parameter int COORD_BITS      = 16,
    parameter int SCALE_FRAC_BITS = 8
)
(
    input  logic                         cal_enable,
    input  axis_cal_t                    cal,
    input  logic [RAW_BITS-1:0]          raw,
    output logic signed [COORD_BITS-1:0] pos
);

    localparam int PROD_BITS = CFG_BITS + RAW_BITS + 1;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam logic signed [SUM_BITS-1:0] COORD_MAX =
        SUM_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_BITS-1:0] COORD_MIN = -COORD_MAX - 1;

    logic signed [PROD_BITS-1:0] scale_ext;
    logic signed [PROD_BITS-1:0] raw_ext;
    logic signed [PROD_BITS-1:0] prod;
    logic signed [PROD_BITS-1:0] prod_shr;
    logic signed [SUM_BITS-1:0]  sum;
    logic signed [SUM_BITS-1:0]  sel;

    always_comb
    begin
        scale_ext = {{(PROD_BITS-CFG_BITS){cal.scale[CFG_BITS-1]}}, cal.scale};
        raw_ext   = $signed({{(PROD_BITS-RAW_BITS){1'b0}}, raw});
        prod      = scale_ext * raw_ext;
        // arithmetic shift rounds toward minus infinity
        prod_shr  = prod >>> SCALE_FRAC_BITS;
        sum       = {prod_shr[PROD_BITS-1], prod_shr}
                  + {{(SUM_BITS-CFG_BITS){cal.offset[CFG_BITS-1]}}, cal.offset};
        sel       = cal_enable ? sum : $signed({{(SUM_BITS-RAW_BITS){1'b0}}, raw});

        if (sel > COORD_MAX)
        begin
            pos = COORD_BITS'(COORD_MAX);
        end
        else if (sel < COORD_MIN)
        begin
            pos = COORD_BITS'(COORD_MIN);
        end
        else
        begin
            pos = COORD_BITS'(sel);
        end
    end

endmodule

`default_nettype wire

// ===== bench/touch_sample_to_pointer_events_tb.sv =====
// Self-checking bench for touch_sample_to_pointer_events: a gesture-level
// stimulus generator, a click scoreboard with its own event predictor.
// Depends on tspe_pkg and the RTL of the block; nothing else.
`timescale 1ns / 1ps

module touch_sample_to_pointer_events_tb;

    import tspe_pkg::*;

    // Block configuration under test
    localparam int COORD_BITS      = 16;
    localparam int SCALE_FRAC_BITS = 8;
    localparam int TIME_BITS       = 32;
    localparam int IN_BITS         = 80;
    localparam int OUT_BITS        = 40;

    localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    // Register indexes the block does not decode; writes there must be ignored
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam int RESET_CYCLES    = 12;
    localparam int DRAIN_CYCLES    = 10;   // margin over the pipeline latency
    localparam int HOLD_CYCLES     = 200;  // long receiver hold-off
    localparam int WATCHDOG_LIMIT  = 2000; // quiet cycles before giving up
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 50;

    typedef struct packed {
        logic [15:0] raw_x;
        logic [15:0] raw_y;
        logic [15:0] pressure;
        logic [31:0] sample_time;
    } sample_t;

    typedef struct packed {
        event_kind_t        kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               dbl;
        logic               triple;
        logic               last;
    } pointer_event_t;

    // ------------------------------------------------------------------
    // Click scoreboard: predicts the events of every accepted sample and
    // checks the events coming out against them in order.
    // ------------------------------------------------------------------
    class click_scoreboard;
        // register copy
        bit                 cal_on;
        logic signed [15:0] x_gain, x_shift, y_gain, y_shift;
        logic [15:0]        window_ticks;
        // tracking state
        logic signed [15:0] last_x, last_y;
        bit                 was_pressed;
        logic [31:0]        recent_press_t, older_press_t;
        bit                 recent_press_ok, older_press_ok;
        bit                 dbl_flag, tpl_flag;

        pointer_event_t     pending[$];
        int                 errors;
        int                 n_checked, n_down, n_up, n_double, n_triple;

        function new();
            cal_on          = 1'b0;
            x_gain          = SCALE_RESET;
            x_shift         = OFFSET_RESET;
            y_gain          = SCALE_RESET;
            y_shift         = OFFSET_RESET;
            window_ticks    = CLICK_WINDOW_RESET;
            last_x          = '0;
            last_y          = '0;
            was_pressed     = 1'b0;
            recent_press_t  = '0;
            older_press_t   = '0;
            recent_press_ok = 1'b0;
            older_press_ok  = 1'b0;
            dbl_flag        = 1'b0;
            tpl_flag        = 1'b0;
            errors          = 0;
            n_checked       = 0;
            n_down          = 0;
            n_up            = 0;
            n_double        = 0;
            n_triple        = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                REG_CAL_ENABLE:   cal_on       = val[0];
                REG_X_SCALE:      x_gain       = val;
                REG_X_OFFSET:     x_shift      = val;
                REG_Y_SCALE:      y_gain       = val;
                REG_Y_OFFSET:     y_shift      = val;
                REG_CLICK_WINDOW: window_ticks = val;
                default: ;
            endcase
        endfunction

        // gain/offset per axis; >>> on a signed product rounds toward -inf
        function logic signed [15:0] map_axis(logic [15:0] raw, logic signed [15:0] gain,
                                              logic signed [15:0] shift);
            longint prod;
            longint sum;
            if (!cal_on)
                sum = longint'(raw);
            else
            begin
                prod = longint'(gain) * longint'(raw);
                sum  = (prod >>> SCALE_FRAC_BITS) + longint'(shift);
            end
            if (sum > COORD_MAX)
                sum = COORD_MAX;
            else if (sum < COORD_MIN)
                sum = COORD_MIN;
            return sum[15:0];
        endfunction

        // returns the number of events this sample produces
        function int note_sample(sample_t smp);
            pointer_event_t     evs[2];
            logic signed [15:0] x, y;
            bit                 pressed;
            logic [31:0]        since_recent, since_older;
            logic [16:0]        window_x2;
            int                 n;
            x         = map_axis(smp.raw_x, x_gain, x_shift);
            y         = map_axis(smp.raw_y, y_gain, y_shift);
            pressed   = (smp.pressure != 16'h0);
            window_x2 = {window_ticks, 1'b0};
            n         = 0;
            if (pressed || was_pressed)
            begin
                evs[n] = '{kind: EV_MOVE, pos_x: x, pos_y: y, dbl: 1'b0, triple: 1'b0,
                           last: 1'b0};
                n++;
            end
            if (pressed && !was_pressed)
            begin
                since_recent = smp.sample_time - recent_press_t;
                since_older  = smp.sample_time - older_press_t;
                dbl_flag = recent_press_ok && (since_recent <= 32'(window_ticks));
                tpl_flag = older_press_ok && (since_older <= 32'(window_x2));
                evs[n] = '{kind: EV_DOWN, pos_x: x, pos_y: y, dbl: dbl_flag,
                           triple: tpl_flag, last: 1'b0};
                n++;
                if (tpl_flag)
                begin
                    // a triple click starts the press history over
                    recent_press_t  = '0;
                    recent_press_ok = 1'b0;
                    older_press_t   = '0;
                    older_press_ok  = 1'b0;
                end
                else
                begin
                    older_press_t   = recent_press_t;
                    older_press_ok  = recent_press_ok;
                    recent_press_t  = smp.sample_time;
                    recent_press_ok = 1'b1;
                end
            end
            else if (!pressed && was_pressed)
            begin
                evs[n] = '{kind: EV_UP, pos_x: last_x, pos_y: last_y, dbl: dbl_flag,
                           triple: tpl_flag, last: 1'b0};
                n++;
            end
            if (n > 0)
                evs[n-1].last = 1'b1;
            for (int i = 0; i < n; i++)
                pending.push_back(evs[i]);
            last_x      = x;
            last_y      = y;
            was_pressed = pressed;
            return n;
        endfunction

        function void check_event(pointer_event_t got);
            pointer_event_t exp;
            if (pending.size() == 0)
            begin
                $error("unexpected event: kind %0d pos (%0d,%0d)",
                       got.kind, got.pos_x, got.pos_y);
                errors++;
                return;
            end
            exp = pending.pop_front();
            n_checked++;
            if (got.kind !== exp.kind)
            begin
                $error("event_kind: expected %0d, actual %0d", exp.kind, got.kind);
                errors++;
            end
            if (got.pos_x !== exp.pos_x)
            begin
                $error("pos_x: expected %0d, actual %0d", exp.pos_x, got.pos_x);
                errors++;
            end
            if (got.pos_y !== exp.pos_y)
            begin
                $error("pos_y: expected %0d, actual %0d", exp.pos_y, got.pos_y);
                errors++;
            end
            if (got.dbl !== exp.dbl)
            begin
                $error("dbl_click: expected %0d, actual %0d", exp.dbl, got.dbl);
                errors++;
            end
            if (got.triple !== exp.triple)
            begin
                $error("trp_click: expected %0d, actual %0d", exp.triple, got.triple);
                errors++;
            end
            if (got.last !== exp.last)
            begin
                $error("last_of_run: expected %0d, actual %0d", exp.last, got.last);
                errors++;
            end
            if (exp.kind == EV_DOWN)
                n_down++;
            if (exp.kind == EV_UP)
                n_up++;
            if (exp.kind != EV_MOVE && exp.dbl)
                n_double++;
            if (exp.kind != EV_MOVE && exp.triple)
                n_triple++;
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and its signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [2:0]          cfg_index = '0;
    logic [CFG_BITS-1:0] cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata   = '0;   // raw_x, raw_y, pressure, sample_time
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [OUT_BITS-1:0] m_tdata;          // pos_x, pos_y, dbl_click, trp_click
    logic [1:0]          m_tuser;          // event_kind
    logic                m_tlast;          // last_of_run

    touch_sample_to_pointer_events #(
        .COORD_BITS      (COORD_BITS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS),
        .TIME_BITS       (TIME_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    click_scoreboard sb;

    // bench-side bookkeeping
    logic [31:0] tick          = '0;   // running timestamp of generated samples
    int          cur_window    = 250;  // click window the generator aims at
    bit          no_idle       = 1'b0; // phase runs both sides back to back
    bit          hold_req      = 1'b0; // asks the receiver for one long hold-off
    int          samples_sent  = 0;
    int          event_samples = 0;    // accepted samples that produced events
    int          settings_used = 0;
    int          in_stalls     = 0;    // cycles with s_tvalid high, s_tready low

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driving tasks. All outputs of the bench change by NBA right after a
    // rising edge; handshakes are judged from the values held at the edge.
    // ------------------------------------------------------------------

    // one register write; the caller lowers cfg_wr_en after its last write
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    // full register set, plus writes to the undecoded indexes around it
    task automatic apply_settings(input bit cal, input logic [15:0] xs, xo, ys, yo, win);
        write_reg(REG_SPARE_LO, 16'($urandom));
        write_reg(REG_CAL_ENABLE, {15'b0, cal});
        write_reg(REG_X_SCALE, xs);
        write_reg(REG_X_OFFSET, xo);
        write_reg(REG_Y_SCALE, ys);
        write_reg(REG_Y_OFFSET, yo);
        write_reg(REG_CLICK_WINDOW, win);
        write_reg(REG_SPARE_HI, 16'($urandom));
        cfg_wr_en  <= 1'b0;
        cur_window  = int'(win);
        settings_used++;
    endtask

    // offer one sample after a random gap and hold it until it transfers
    task automatic send_sample(input sample_t smp);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {smp.sample_time, smp.pressure, smp.raw_y, smp.raw_x};
        do
            @(posedge clk);
        while (!s_tready);
        samples_sent++;
        if (sb.note_sample(smp) > 0)
            event_samples++;
    endtask

    function automatic sample_t mk_sample(input logic [15:0] x, y, p, input logic [31:0] t);
        sample_t s;
        s.raw_x       = x;
        s.raw_y       = y;
        s.pressure    = p;
        s.sample_time = t;
        return s;
    endfunction

    // Random sample of a gesture. Steps between samples mostly stay within
    // half a click window so that click runs land inside the windows; now and
    // then the clock jumps by a whole window or by anything (wrap, backwards).
    // Noise samples take a random time and a random contact.
    function automatic sample_t touch_sample(input bit press, input bit noisy);
        sample_t s;
        s.raw_x = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 1023)) : 16'($urandom);
        s.raw_y = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 1023)) : 16'($urandom);
        if (noisy)
        begin
            s.pressure = $urandom_range(0, 1) ? 16'($urandom) : 16'h0;
            tick       = $urandom;
        end
        else
        begin
            s.pressure = press ? 16'($urandom_range(1, 65535)) : 16'h0;
            case ($urandom_range(0, 15))
                0:       tick = tick + $urandom;
                1:       tick = tick + 32'(cur_window);
                default: tick = tick + $urandom_range(0, cur_window / 2 + 1);
            endcase
        end
        s.sample_time = tick;
        return s;
    endfunction

    // Random part of a phase, made of whole gestures. Most are click runs and
    // drags with random content; the rest are idle stretches and noise.
    task automatic run_gestures(input int target);
        int start_count;
        int kind;
        start_count = event_samples;
        while (event_samples - start_count < target)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                // run of one to four taps
                repeat ($urandom_range(1, 4))
                begin
                    repeat ($urandom_range(1, 3)) send_sample(touch_sample(1'b1, 1'b0));
                    repeat ($urandom_range(1, 2)) send_sample(touch_sample(1'b0, 1'b0));
                end
            end
            else if (kind <= 7)
            begin
                // drag
                repeat ($urandom_range(3, 10)) send_sample(touch_sample(1'b1, 1'b0));
                send_sample(touch_sample(1'b0, 1'b0));
            end
            else if (kind == 8)
                repeat ($urandom_range(1, 4)) send_sample(touch_sample(1'b0, 1'b0));
            else
                repeat ($urandom_range(1, 6)) send_sample(touch_sample(1'b0, 1'b1));
        end
        s_tvalid <= 1'b0;
    endtask

    // Directed samples under reset register values (no calibration, window
    // 250): no contact, raw extremes with saturation, press/move/release,
    // double and triple clicks on the exact window bounds, a press past the
    // window, a triple one tick past its bound, the triple clearing the history,
    // wrap of the timestamp and a timestamp going backwards.
    task automatic directed_run();
        send_sample(mk_sample(16'h0000, 16'h0000, 16'h0000, 32'd0));      // no contact
        send_sample(mk_sample(16'hFFFF, 16'hFFFF, 16'h0000, 32'd50));     // still none
        send_sample(mk_sample(16'hFFFF, 16'h8000, 16'hFFFF, 32'd100));    // first press
        send_sample(mk_sample(16'h7FFF, 16'h0000, 16'h0001, 32'd110));    // move
        send_sample(mk_sample(16'h0000, 16'h0000, 16'h0000, 32'd120));    // release
        send_sample(mk_sample(16'h1234, 16'h4321, 16'h8000, 32'd350));    // double, on bound
        send_sample(mk_sample(16'h0001, 16'h0002, 16'h0000, 32'd360));
        send_sample(mk_sample(16'h00FF, 16'hFF00, 16'h5555, 32'd600));    // triple, on bound
        send_sample(mk_sample(16'h0003, 16'h0004, 16'h0000, 32'd610));    // up repeats flags
        send_sample(mk_sample(16'h0005, 16'h0006, 16'hAAAA, 32'd620));    // history cleared
        send_sample(mk_sample(16'h0007, 16'h0008, 16'h0000, 32'd630));
        send_sample(mk_sample(16'h0009, 16'h000A, 16'h0002, 32'd881));    // past window
        send_sample(mk_sample(16'h000B, 16'h000C, 16'h0000, 32'd890));
        send_sample(mk_sample(16'h000D, 16'h000E, 16'h7FFF, 32'd1121));   // double, not triple
        send_sample(mk_sample(16'h000F, 16'h0010, 16'h0000, 32'd1130));
        send_sample(mk_sample(16'h0011, 16'h0012, 16'h0000, 32'd1140));   // no contact
        send_sample(mk_sample(16'h8000, 16'h7FFF, 16'h0100, 32'hFFFF_FFA0));
        send_sample(mk_sample(16'h8001, 16'h7FFE, 16'h0000, 32'hFFFF_FFB0));
        send_sample(mk_sample(16'h0013, 16'h0014, 16'h0010, 32'h0000_0050)); // across wrap
        send_sample(mk_sample(16'h0015, 16'h0016, 16'h0000, 32'h0000_0058));
        send_sample(mk_sample(16'h0017, 16'h0018, 16'h0400, 32'h0000_0040)); // backwards
        send_sample(mk_sample(16'h0019, 16'h001A, 16'h0000, 32'h0000_0060));
        s_tvalid <= 1'b0;
        tick = 32'h0000_0060;
    endtask

    // nothing expected any more, then let samples without events drain too
    task automatic wait_idle();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall before each event, one long hold-off on
    // request so the event queue fills and the input side backs up.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        pointer_event_t got;
        int             stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
                stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got.kind   = event_kind_t'(m_tuser);
            got.pos_x  = m_tdata[15:0];
            got.pos_y  = m_tdata[31:16];
            got.dbl    = m_tdata[32];
            got.triple = m_tdata[33];
            got.last   = m_tlast;
            sb.check_event(got);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run after too many cycles without any transfer
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (s_tvalid && !s_tready)
                in_stalls++;
        end
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed samples on reset values, then phases of
    // random gestures, each under its own register setting.
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_run();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle();
            no_idle = (ph == 1 || ph == 2 || ph == 5);
            case (ph)
                0: apply_settings(1'b1, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 16'd250);
                // largest gains and offsets: saturation at the top, mixed on y
                1: apply_settings(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF);
                // most negative gains, zero click window
                2: apply_settings(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000);
                // calibration off with non-default registers
                3: apply_settings(1'b0, 16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom_range(0, 600)));
                4: apply_settings(1'b1, 16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom_range(0, 1000)));
                // zero gain and a fraction-only gain, offset -1
                5: apply_settings(1'b1, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 16'd16);
                default: apply_settings(1'b1, 16'($urandom), 16'($urandom), 16'($urandom),
                                        16'($urandom), 16'($urandom));
            endcase
            // back pressure: receiver stops while the sender keeps offering
            if (ph == 1)
                hold_req = 1'b1;
            run_gestures(ITEMS_PER_PHASE);
        end
        wait_idle();

        $display("run: %0d samples over %0d register settings, %0d events checked",
                 samples_sent, settings_used + 1, sb.n_checked);
        $display("run: %0d down, %0d up, %0d double, %0d triple, %0d input stall cycles",
                 sb.n_down, sb.n_up, sb.n_double, sb.n_triple, in_stalls);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
